>>> rtl/core/clcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the character-LCD write front end.
// No dependencies; the files that use it refer to it by scoped names.
package clcd_pkg;

  // Request codes on the func field
  typedef enum logic [1:0] {
    FUNC_DATA   = 2'd0,
    FUNC_CMD    = 2'd1,
    FUNC_CURSOR = 2'd2,
    FUNC_NUMBER = 2'd3
  } func_t;

  localparam logic [7:0]  CUR_LINE0  = 8'h80;
  localparam logic [7:0]  CUR_LINE1  = 8'hC0;
  localparam logic [7:0]  COL_LIMIT  = 8'd15;
  localparam logic [7:0]  LINE_LIMIT = 8'd2;
  localparam logic [3:0]  ASCII_HI   = 4'h3;   // upper nibble of '0'..'9'
  // ceil(2^35 / 10): q = (v * RECIP10) >> 35 is exact for 32-bit v
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Controller to datapath
  typedef struct packed {
    logic ready;   // input channel may take a word
    logic load;    // capture the accepted request
    logic mul;     // reciprocal multiply of the remaining value
    logic digit;   // store one digit, keep the quotient
    logic emit;    // load one bus transfer into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_is_num;
    logic div_done;    // quotient is zero or the digit store is full
    logic slot_free;   // output register can take a transfer this cycle
    logic final_xfer;  // transfer on offer is the last of the request
  } sts_t;

endpackage

>>> rtl/core/clcd_req_if.sv
`timescale 1ns / 1ps
// Request channel: one word per display request.
// Uses clcd_pkg for the function code type.
interface clcd_req_if;
  logic               valid;
  logic               ready;
  clcd_pkg::func_t    func;
  logic [31:0]        value;
  logic [7:0]         line;
  logic [7:0]         column;

  modport source (output valid, func, value, line, column, input ready);
  modport sink   (input valid, func, value, line, column, output ready);
endinterface

>>> rtl/core/clcd_xfer_if.sv
`timescale 1ns / 1ps
// Bus transfer channel: one word per LCD bus transfer.
// No dependencies.
interface clcd_xfer_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_value;
  logic       last;

  modport source (output valid, reg_select, bus_value, last, input ready);
  modport sink   (input valid, reg_select, bus_value, last, output ready);
endinterface

>>> rtl/core/clcd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the LCD front end: accept, digit loop, transfer loop.
// Depends on clcd_pkg (cmd_t, sts_t).
module clcd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  clcd_pkg::sts_t sts,
  output clcd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIG  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        // hold off the input while reset is asserted
        cmd.ready = rst_n;
        if (rst_n && sts.in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_is_num ? S_MUL : S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIG;
      end
      S_DIG: begin
        cmd.digit = 1'b1;
        state_nxt = sts.div_done ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free && sts.final_xfer) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/clcd_dp.sv
`timescale 1ns / 1ps
// Datapath: request capture, divide-by-ten digit store, nibble split, output register.
// Depends on clcd_pkg, clcd_req_if and clcd_xfer_if.
module clcd_dp #(
  parameter int MAX_DIGITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  clcd_req_if.sink       in_ch,
  clcd_xfer_if.source    out_ch,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  clcd_pkg::cmd_t cmd,
  output clcd_pkg::sts_t sts
);

  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [IW-1:0] IDX_TOP = IW'(MAX_DIGITS - 1);

  logic          nibble_r;
  logic          num_r;
  logic          rs_r;
  logic [7:0]    byte_r;
  logic [31:0]   val_r;
  logic [63:0]   prod_r;
  logic [IW-1:0] idx_r;
  logic          phase_r;
  logic [3:0]    digit_r [MAX_DIGITS];

  logic          out_valid_r;
  logic          out_rs_r;
  logic [7:0]    out_bus_r;
  logic          out_last_r;

  logic [31:0]   quot;
  logic [31:0]   quot10;
  logic [31:0]   rem;
  logic          div_done;
  logic [7:0]    cursor_byte;
  logic [7:0]    cur_byte;
  logic [7:0]    bus_word;
  logic          idx_zero;
  logic          final_xfer;
  logic          slot_free;

  // Divide by ten from the registered product
  assign quot   = 32'(prod_r[63:clcd_pkg::RECIP_SHIFT]);
  assign quot10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
  assign rem    = val_r - quot10;
  assign div_done = (quot == 32'd0) || (idx_r == IDX_TOP);

  always_comb begin
    if ((in_ch.line >= clcd_pkg::LINE_LIMIT) || (in_ch.column >= clcd_pkg::COL_LIMIT)) begin
      cursor_byte = clcd_pkg::CUR_LINE0;
    end else if (in_ch.line == 8'd0) begin
      cursor_byte = clcd_pkg::CUR_LINE0 + in_ch.column;
    end else begin
      cursor_byte = clcd_pkg::CUR_LINE1 + in_ch.column;
    end
  end

  assign cur_byte   = num_r ? {clcd_pkg::ASCII_HI, digit_r[idx_r]} : byte_r;
  assign bus_word   = !nibble_r ? cur_byte
                    : (phase_r ? {4'b0000, cur_byte[3:0]} : {4'b0000, cur_byte[7:4]});
  assign idx_zero   = (idx_r == '0);
  assign final_xfer = (!nibble_r || phase_r) && (!num_r || idx_zero);
  assign slot_free  = !out_valid_r || out_ch.ready;

  assign sts.in_valid   = in_ch.valid;
  assign sts.in_is_num  = (in_ch.func == clcd_pkg::FUNC_NUMBER);
  assign sts.div_done   = div_done;
  assign sts.slot_free  = slot_free;
  assign sts.final_xfer = final_xfer;

  assign in_ch.ready       = cmd.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.reg_select = out_rs_r;
  assign out_ch.bus_value  = out_bus_r;
  assign out_ch.last       = out_last_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_r    <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) begin
        nibble_r <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        phase_r <= 1'b0;
        idx_r   <= '0;
      end else if (cmd.digit) begin
        if (!div_done) begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (cmd.emit) begin
        if (nibble_r && !phase_r) begin
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (num_r && !idx_zero) begin
            idx_r <= idx_r - 1'b1;
          end
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r  <= (in_ch.func == clcd_pkg::FUNC_NUMBER);
      rs_r   <= (in_ch.func == clcd_pkg::FUNC_DATA) || (in_ch.func == clcd_pkg::FUNC_NUMBER);
      byte_r <= (in_ch.func == clcd_pkg::FUNC_CURSOR) ? cursor_byte : in_ch.value[7:0];
      val_r  <= in_ch.value;
    end else if (cmd.digit) begin
      val_r <= quot;
    end
    if (cmd.mul) begin
      prod_r <= val_r * clcd_pkg::RECIP10;
    end
    if (cmd.digit) begin
      digit_r[idx_r] <= rem[3:0];
    end
    if (cmd.emit) begin
      out_rs_r   <= rs_r;
      out_bus_r  <= bus_word;
      out_last_r <= final_xfer;
    end
  end

endmodule

>>> rtl/core/char_lcd_write_front_end.sv
`timescale 1ns / 1ps
// Top level of the character-LCD write front end: sequencer plus datapath.
// Depends on clcd_pkg, clcd_req_if, clcd_xfer_if, clcd_ctrl and clcd_dp.
//
//  Channel  Direction  Handshake      Word
//  in_ch    sink       valid / ready  func, value, line, column
//  out_ch   source     valid / ready  reg_select, bus_value, last
//  cfg_*    write-only cfg_we         cfg_wdata = nibble_mode
//
// Sequence: a data, command or cursor word is accepted, then gives one transfer
// in byte mode or two in nibble mode, one transfer per cycle while out_ch does not
// stall. A number takes a multiply step and a digit step per decimal digit in the
// reciprocal divide-by-ten unit, then gives its transfers at the same rate.
// Reset clears the sequencer, nibble_mode and the output register.
// A stalled out_ch holds the transfer in the output register and stalls the
// sequencer; in_ch is ready only while no request is in progress.
module char_lcd_write_front_end #(
  parameter int MAX_DIGITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  clcd_req_if.sink     in_ch,
  clcd_xfer_if.source  out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  clcd_pkg::cmd_t cmd;   // sequencer commands
  clcd_pkg::sts_t sts;   // datapath status

  // Sequence the request: accept, digit loop, transfer loop
  clcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold the request, split numbers into digits, drive the bus word
  clcd_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> tb/clcd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the character-LCD write front end: predicts the bus transfers
// of each request word and compares them with the result channel.
// Depends on clcd_pkg, clcd_req_if and clcd_xfer_if.
module clcd_checker #(
  parameter int MAX_DIGITS = 10
) (
  input  logic  clk,
  input  logic  rst_n,
  clcd_req_if   req,
  clcd_xfer_if  xfer,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  output int    mismatch_count,
  output int    words_pending
);

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_value;
    logic       last;
  } xfer_t;

  xfer_t xfer_q[$];
  logic  nibble_on;
  int    fails;

  initial begin
    fails     = 0;
    nibble_on = 1'b0;
  end

  // Expand one request into its transfers, mark the final one.
  function automatic void predict_transfers(clcd_pkg::func_t f, logic [31:0] v,
                                            logic [7:0] ln, logic [7:0] col);
    logic [7:0]  seq [20];
    logic [3:0]  digits [MAX_DIGITS];
    logic [31:0] rest;
    logic        rs;
    int          nb;
    int          nd;
    xfer_t       t;
    nb = 0;
    rs = 1'b1;
    case (f)
      clcd_pkg::FUNC_DATA: begin
        seq[0] = v[7:0];
        nb = 1;
      end
      clcd_pkg::FUNC_CMD: begin
        rs = 1'b0;
        seq[0] = v[7:0];
        nb = 1;
      end
      clcd_pkg::FUNC_CURSOR: begin
        rs = 1'b0;
        if (ln >= clcd_pkg::LINE_LIMIT || col >= clcd_pkg::COL_LIMIT)
          seq[0] = clcd_pkg::CUR_LINE0;
        else if (ln == 8'd0) seq[0] = clcd_pkg::CUR_LINE0 + col;
        else seq[0] = clcd_pkg::CUR_LINE1 + col;
        nb = 1;
      end
      default: begin
        nd = 0;
        rest = v;
        if (rest == 32'd0) begin
          digits[0] = 4'd0;
          nd = 1;
        end else begin
          while (rest != 32'd0 && nd < MAX_DIGITS) begin
            digits[nd] = 4'(rest % 10);
            rest = rest / 10;
            nd++;
          end
        end
        for (int k = nd - 1; k >= 0; k--) begin
          seq[nb] = {clcd_pkg::ASCII_HI, digits[k]};
          nb++;
        end
      end
    endcase
    for (int i = 0; i < nb; i++) begin
      t.reg_select = rs;
      if (nibble_on) begin
        t.bus_value = {4'h0, seq[i][7:4]};
        t.last = 1'b0;
        xfer_q.push_back(t);
        t.bus_value = {4'h0, seq[i][3:0]};
      end else begin
        t.bus_value = seq[i];
      end
      t.last = (i == nb - 1);
      xfer_q.push_back(t);
    end
  endfunction

  always @(posedge clk) begin
    xfer_t want;
    if (!rst_n) begin
      xfer_q.delete();
      nibble_on = 1'b0;
    end else begin
      if (cfg_we) nibble_on = cfg_wdata;
      // queue the new request first: its transfers go behind any older ones
      if (req.valid && req.ready)
        predict_transfers(req.func, req.value, req.line, req.column);
      if (xfer.valid && xfer.ready) begin
        if (xfer_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected transfer rs=%0b bus=%02h last=%0b",
                     xfer.reg_select, xfer.bus_value, xfer.last);
        end else begin
          want = xfer_q.pop_front();
          if (want.reg_select !== xfer.reg_select
              || want.bus_value !== xfer.bus_value
              || want.last !== xfer.last) begin
            fails++;
            if (fails <= 10)
              $display({"transfer mismatch: expected rs=%0b bus=%02h last=%0b,",
                        " got rs=%0b bus=%02h last=%0b"},
                       want.reg_select, want.bus_value, want.last,
                       xfer.reg_select, xfer.bus_value, xfer.last);
          end
        end
      end
    end
    mismatch_count <= fails;
    words_pending  <= xfer_q.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, request stimulus, receiver stalls and verdict.
// Depends on clcd_pkg, both channel interfaces, the block and clcd_checker.
module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatch_count;
  int   words_pending;
  int   cycles;
  bit   idle_on;    // random idle bursts allowed on both sides
  bit   hold_rx;    // ask the receiver for one long stall

  clcd_req_if  req_ch ();
  clcd_xfer_if xfer_ch ();

  char_lcd_write_front_end #(.MAX_DIGITS(10)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (xfer_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  clcd_checker #(.MAX_DIGITS(10)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req_ch),
    .xfer           (xfer_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: ready by default, short random stalls, one long stall on request.
  initial begin
    xfer_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        // hold off long enough that the block backs up onto its input
        xfer_ch.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        hold_rx = 1'b0;
        xfer_ch.ready <= 1'b1;
      end else if (idle_on && rst_n && $urandom_range(0, 3) == 0) begin
        xfer_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        xfer_ch.ready <= 1'b1;
      end else begin
        xfer_ch.ready <= rst_n;
      end
    end
  end

  // Offer one request word and wait for its handshake. Keep valid high
  // afterwards so back-to-back words need no extra edge.
  task automatic send_request(clcd_pkg::func_t f, logic [31:0] v,
                              logic [7:0] ln, logic [7:0] col);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.func   <= f;
    req_ch.value  <= v;
    req_ch.line   <= ln;
    req_ch.column <= col;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every predicted transfer has come out.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write nibble_mode while the block is idle.
  task automatic set_nibble_mode(logic m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random word: mostly well-formed cursors, numbers biased to few digits,
  // upper bits of value and out-of-range positions still exercised.
  task automatic send_random_request();
    clcd_pkg::func_t f;
    logic [31:0]     v;
    logic [7:0]      ln;
    logic [7:0]      col;
    f   = clcd_pkg::func_t'($urandom_range(0, 3));
    v   = $urandom();
    ln  = 8'($urandom_range(0, 255));
    col = 8'($urandom_range(0, 255));
    if (f == clcd_pkg::FUNC_CURSOR && $urandom_range(0, 3) != 0) begin
      ln  = 8'($urandom_range(0, 1));
      col = 8'($urandom_range(0, 14));
    end
    if (f == clcd_pkg::FUNC_NUMBER) begin
      case ($urandom_range(0, 7))
        0:       v = 32'd0;
        1:       v = 32'hFFFF_FFFF;
        2, 3:    v = $urandom_range(0, 9);
        4, 5:    v = $urandom_range(0, 9999);
        default: ;
      endcase
    end
    send_request(f, v, ln, col);
  endtask

  task automatic random_phase(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 5) hold_rx = 1'b1;
      send_random_request();
    end
  endtask

  initial begin
    // drive every input from time zero
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.func    <= clcd_pkg::FUNC_DATA;
    req_ch.value   <= 32'd0;
    req_ch.line    <= 8'd0;
    req_ch.column  <= 8'd0;
    idle_on        = 1'b1;
    hold_rx        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part in nibble mode: field extremes, cursor corner cases and numbers.
    set_nibble_mode(1'b1);
    send_request(clcd_pkg::FUNC_DATA,   32'h0000_0000, 8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_DATA,   32'hFFFF_FFFF, 8'd255, 8'd255);
    send_request(clcd_pkg::FUNC_CMD,    32'h1234_5601, 8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_CMD,    32'h0000_00FF, 8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_CURSOR, 32'd0,         8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_CURSOR, 32'd0,         8'd0,   8'd14);
    send_request(clcd_pkg::FUNC_CURSOR, 32'd0,         8'd1,   8'd0);
    send_request(clcd_pkg::FUNC_CURSOR, 32'd0,         8'd1,   8'd14);
    // out-of-range position: only the home command of line 0
    send_request(clcd_pkg::FUNC_CURSOR, 32'd0,         8'd0,   8'd15);
    send_request(clcd_pkg::FUNC_CURSOR, 32'd0,         8'd2,   8'd3);
    send_request(clcd_pkg::FUNC_CURSOR, 32'hFFFF_FFFF, 8'd255, 8'd255);
    // zero prints one digit; no leading zeros elsewhere
    send_request(clcd_pkg::FUNC_NUMBER, 32'd0,         8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_NUMBER, 32'd9,         8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_NUMBER, 32'd10,        8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_NUMBER, 32'd1000000000, 8'd0,  8'd0);
    send_request(clcd_pkg::FUNC_NUMBER, 32'hFFFF_FFFF, 8'd0,   8'd0);

    // Byte mode: a few extremes, then random words with one long receiver stall.
    set_nibble_mode(1'b0);
    send_request(clcd_pkg::FUNC_DATA,   32'hFFFF_FF00, 8'd0,   8'd0);
    send_request(clcd_pkg::FUNC_CURSOR, 32'd0,         8'd1,   8'd15);
    send_request(clcd_pkg::FUNC_NUMBER, 32'd999999999, 8'd0,   8'd0);
    random_phase(50, 1'b1);

    set_nibble_mode(1'b1);
    random_phase(50, 1'b0);

    set_nibble_mode(1'b0);
    random_phase(50, 1'b0);

    // last stretch: nibble mode, no idling on either side
    set_nibble_mode(1'b1);
    idle_on = 1'b0;
    random_phase(50, 1'b0);

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
